// File: rtl/pat_pkg.sv
`default_nettype none
package pat_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int ADDR_W      = 48;
  localparam int TIME_W      = 32;

  localparam logic [1:0] REQ_SEEN  = 2'd0;
  localparam logic [1:0] REQ_LEARN = 2'd1;
  localparam logic [1:0] REQ_AGE   = 2'd2;

  localparam logic REG_OWN_ADDRESS = 1'b0;
  localparam logic REG_TIMEOUT_MS  = 1'b1;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

  // Token walking the row of cells, gathering lookup and aging results.
  typedef struct packed {
    logic              active;
    logic [1:0]        req;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    logic              found;
    logic [SLOT_W-1:0] found_slot;
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  expired;
  } tok_t;

  // Write broadcast issued once the token has left the last cell.
  typedef struct packed {
    logic              en;
    logic              fill;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
  } wr_t;

endpackage
`default_nettype wire

// File: rtl/peer_address_table_with_aging.sv
// Channel   Signals                                       Handshake
// request   req_type_i, peer_address_i, now_ms_i          start_i && !busy_o
// result    hit_o, added_o, table_full_o, slot_o,         done_o, one cycle
//           peer_count_o, expired_count_o
// config    cfg_index_i, cfg_data_i                       cfg_valid_i && cfg_ready_o
//
// An item's token passes one cell of the row of TABLE_SLOTS-1 peer slots per
// cycle; once it leaves the last cell, any write is committed and the result
// registered together, and a new item may start as soon as the result shows.
// Reset clears every peer slot; slot zero is the own address and always valid.
// The receiver cannot stall, so done_o is a single-cycle strobe.
`default_nettype none
module peer_address_table_with_aging (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [47:0] peer_address_i,
  input  wire logic [31:0] now_ms_i,
  output logic             done_o,
  output logic             hit_o,
  output logic             added_o,
  output logic             table_full_o,
  output logic [3:0]       slot_o,
  output logic [4:0]       peer_count_o,
  output logic [3:0]       expired_count_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);

  localparam int N = pat_pkg::TABLE_SLOTS;

  logic [pat_pkg::ADDR_W-1:0] own_q;
  logic [pat_pkg::TIME_W-1:0] timeout_q;
  logic                       busy_q;
  logic                       done_q;
  logic                       hit_q, added_q, full_q;
  logic [3:0]                 slot_q;
  logic [4:0]                 count_q;
  logic [3:0]                 expired_q;

  pat_pkg::tok_t              chain [N];
  pat_pkg::tok_t              fin;
  pat_pkg::wr_t               wr;
  logic                       accept;
  logic                       lookup;
  logic                       hit_d, added_d, full_d;
  logic [pat_pkg::SLOT_W-1:0] slot_d;
  logic [pat_pkg::CNT_W-1:0]  count_d;
  logic [pat_pkg::CNT_W-1:0]  expired_d;

  assign accept      = start_i && !busy_q;
  assign cfg_ready_o = 1'b1;
  assign lookup      = (req_type_i == pat_pkg::REQ_SEEN) || (req_type_i == pat_pkg::REQ_LEARN);

  always_comb begin
    chain[0]            = '0;
    chain[0].active     = accept;
    chain[0].req        = req_type_i;
    chain[0].addr       = peer_address_i;
    chain[0].now        = now_ms_i;
    chain[0].found      = lookup && (peer_address_i == own_q);
    chain[0].count      = pat_pkg::CNT_W'(1);
  end

  for (genvar k = 1; k < N; k++) begin : g_cell
    pat_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (pat_pkg::SLOT_W'(k)),
      .timeout_i (timeout_q),
      .tok_i     (chain[k-1]),
      .wr_i      (wr),
      .tok_o     (chain[k])
    );
  end

  assign fin = chain[N-1];

  always_comb begin
    wr        = '0;
    wr.addr   = fin.addr;
    wr.now    = fin.now;
    hit_d     = 1'b0;
    added_d   = 1'b0;
    full_d    = 1'b0;
    slot_d    = '0;
    count_d   = fin.count;
    expired_d = '0;
    unique case (1'b1)
      (fin.req == pat_pkg::REQ_SEEN) || (fin.req == pat_pkg::REQ_LEARN): begin
        if (fin.found) begin
          hit_d  = 1'b1;
          slot_d = fin.found_slot;
          // Only a seen request refreshes, and never the own slot.
          wr.en   = fin.active && (fin.req == pat_pkg::REQ_SEEN) && (fin.found_slot != '0);
          wr.slot = fin.found_slot;
        end else if (fin.free_ok) begin
          added_d = 1'b1;
          slot_d  = fin.free_slot;
          count_d = fin.count + pat_pkg::CNT_W'(1);
          wr.en   = fin.active;
          wr.fill = 1'b1;
          wr.slot = fin.free_slot;
        end else begin
          full_d = 1'b1;
        end
      end
      fin.req == pat_pkg::REQ_AGE: begin
        expired_d = fin.expired;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q     <= '0;
      timeout_q <= pat_pkg::TIMEOUT_RESET;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pat_pkg::REG_OWN_ADDRESS: own_q     <= cfg_data_i;
          pat_pkg::REG_TIMEOUT_MS:  timeout_q <= cfg_data_i[pat_pkg::TIME_W-1:0];
        endcase
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (fin.active) begin
        busy_q <= 1'b0;
      end
      done_q <= fin.active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin.active) begin
      hit_q     <= hit_d;
      added_q   <= added_d;
      full_q    <= full_d;
      slot_q    <= 4'(slot_d);
      count_q   <= 5'(count_d);
      expired_q <= 4'(expired_d);
    end
  end

  assign busy_o          = busy_q;
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign added_o         = added_q;
  assign table_full_o    = full_q;
  assign slot_o          = slot_q;
  assign peer_count_o    = count_q;
  assign expired_count_o = expired_q;

endmodule
`default_nettype wire

// File: rtl/pat_cell.sv
`default_nettype none
module pat_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [pat_pkg::SLOT_W-1:0] idx_i,
  input  wire logic [pat_pkg::TIME_W-1:0] timeout_i,
  input  wire pat_pkg::tok_t              tok_i,
  input  wire pat_pkg::wr_t               wr_i,
  output pat_pkg::tok_t                   tok_o
);

  logic                       valid_q, valid_d;
  logic                       active_q;
  logic [pat_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [pat_pkg::TIME_W-1:0] seen_q, seen_d;
  pat_pkg::tok_t              tok_q, tok_d;
  logic                       lookup;
  logic                       aged;

  assign lookup = (tok_i.req == pat_pkg::REQ_SEEN) || (tok_i.req == pat_pkg::REQ_LEARN);
  assign aged   = (tok_i.now - seen_q) > timeout_i;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    addr_d  = addr_q;
    seen_d  = seen_q;
    if (tok_i.active) begin
      if (lookup && !tok_i.found && valid_q && (addr_q == tok_i.addr)) begin
        tok_d.found      = 1'b1;
        tok_d.found_slot = idx_i;
      end
      if (lookup && !tok_i.free_ok && !valid_q) begin
        tok_d.free_ok   = 1'b1;
        tok_d.free_slot = idx_i;
      end
      if ((tok_i.req == pat_pkg::REQ_AGE) && valid_q && aged) begin
        valid_d       = 1'b0;
        tok_d.expired = tok_i.expired + pat_pkg::CNT_W'(1);
      end
      if (valid_d) begin
        tok_d.count = tok_i.count + pat_pkg::CNT_W'(1);
      end
    end
    // The broadcast never coincides with the token passing this cell.
    if (wr_i.en && (wr_i.slot == idx_i)) begin
      seen_d = wr_i.now;
      if (wr_i.fill) begin
        valid_d = 1'b1;
        addr_d  = wr_i.addr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      active_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      active_q <= tok_d.active;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    seen_q <= seen_d;
    tok_q  <= tok_d;
  end

  // The active flag comes from the reset register, the payload from the other.
  always_comb begin
    tok_o        = tok_q;
    tok_o.active = active_q;
  end

endmodule
`default_nettype wire

// File: rtl/pat_checker.sv
`default_nettype none
module pat_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic       done_o,
  input wire logic       hit_o,
  input wire logic       added_o,
  input wire logic       table_full_o,
  input wire logic [3:0] slot_o,
  input wire logic [4:0] peer_count_o,
  input wire logic [3:0] expired_count_o
);

  // An accepted item keeps the block busy until its result is produced.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("block not busy after accepting an item");

  a_outcome_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $countones({hit_o, added_o, table_full_o}) <= 1)
    else $error("more than one outcome flagged");

  a_full_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && table_full_o |-> slot_o == 4'd0)
    else $error("full table reported with a slot");

  a_own_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> peer_count_o != 5'd0)
    else $error("own entry missing from peer count");

  a_expiry_only_aging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (expired_count_o != 4'd0) |-> !hit_o && !added_o && !table_full_o)
    else $error("expiry reported on a lookup item");

endmodule

bind peer_address_table_with_aging pat_checker u_pat_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .hit_o           (hit_o),
  .added_o         (added_o),
  .table_full_o    (table_full_o),
  .slot_o          (slot_o),
  .peer_count_o    (peer_count_o),
  .expired_count_o (expired_count_o)
);
`default_nettype wire
